FILE: sv/atan2_angle_index_macros.svh
// Assertion helpers for the RTL; clocked on clk, idle while arst_n is low.
`ifndef ATAN2_ANGLE_INDEX_MACROS_SVH
`define ATAN2_ANGLE_INDEX_MACROS_SVH

// Condition must never hold.
`define AAI_NEVER(name, cond, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AAI_IMPLY(name, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/aai_pkg.sv
package aai_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int MID_DEPTH       = 4;
	localparam int OUTQ_DEPTH      = 32;
	localparam int Q_BITS          = 11;
	localparam int Z_W             = 12;
	localparam int ANGLE_W         = 10;

	localparam logic signed [11:0] K_N1     = 12'sd995;
	localparam logic [18:0]        K_N2_MAG = 19'd196;
	localparam logic signed [18:0] K_M1     = 19'sd158595;
	localparam logic signed [18:0] K_M2     = 19'sd174080;
	localparam logic signed [21:0] K_B2     = 22'sd25275;
	localparam logic signed [21:0] K_B3     = 22'sd1022276;
	localparam logic signed [21:0] K_B4     = 22'sd11673;
	localparam logic signed [21:0] K_B5     = 22'sd1059225;
	localparam logic signed [21:0] K_FULL   = 22'sd1048576;
	localparam logic signed [14:0] K_PI     = 15'sd3217;
	localparam logic signed [14:0] K_HALFPI = 15'sd1608;

	localparam logic [ANGLE_W-1:0] ANGLE_UP   = 10'd256;
	localparam logic [ANGLE_W-1:0] ANGLE_DOWN = 10'd768;
	localparam logic [ANGLE_W-1:0] ANGLE_ZERO = 10'd0;

	typedef enum logic [2:0] {
		OCT_XPOS_YPOS,
		OCT_XPOS_YNEG,
		OCT_XNEG_YPOS,
		OCT_XNEG_YNEG,
		OCT_YPOS,
		OCT_YNEG,
		OCT_AXIS
	} oct_t;

	typedef struct packed {
		oct_t               oct;
		logic               neg;
		logic [ANGLE_W-1:0] axis_idx;
	} ctrl_t;

endpackage

FILE: sv/atan2_angle_index.sv
// Path: an input transfer passes the front queue, the divider, the polynomial pipeline and the result queue.
// Throughput: one vector per cycle while output credits remain, else input stalls; the
// 11-stage restoring divider and 5-stage polynomial pipeline take a new operand every cycle.
// Reset: arst_n clears both queues, the pipeline valid bits and the credit count;
// the block takes input as soon as reset is released.
module atan2_angle_index #(
	parameter int COORD_WIDTH = aai_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic signed [COORD_WIDTH-1:0]  x_coord,
	input  logic signed [COORD_WIDTH-1:0]  y_coord,
	output logic                           empty,
	input  logic                           pop,
	output logic [aai_pkg::ANGLE_W-1:0]    angle_index
);
	import aai_pkg::*;

	localparam int W      = COORD_WIDTH;
	localparam int MID_W  = 2 * W + $bits(ctrl_t);
	localparam int CRED_W = $clog2(OUTQ_DEPTH + 1);

	// Front: classify the vector by octant and pick dividend and divisor.
	logic [W-1:0] f_num, f_den;
	ctrl_t        f_ctrl;

	aai_front #(.COORD_WIDTH(W)) u_front (
		.x_coord (x_coord),
		.y_coord (y_coord),
		.num     (f_num),
		.den     (f_den),
		.ctrl    (f_ctrl)
	);

	// Queue between front and back; full here is what the input side sees.
	logic [MID_W-1:0]              mid_rdata;
	logic                          mid_empty, mid_full;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
	logic                          issue;
	logic [W-1:0]                  b_num, b_den;
	ctrl_t                         b_ctrl;

	aai_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_midq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_num, f_den, f_ctrl}),
		.pop    (issue),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.full   (mid_full),
		.count  (mid_count)
	);

	assign full = mid_full;
	assign {b_num, b_den, b_ctrl} = mid_rdata;

	// Back: reserve an output slot for each item issued so the pipeline never
	// has to hold; release the slot when the result is transferred out.
	logic [CRED_W-1:0] credit_q;
	logic              out_pop;

	assign issue   = !mid_empty && (credit_q != CRED_W'(OUTQ_DEPTH));
	assign out_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (issue && !out_pop) begin
			credit_q <= credit_q + 1'b1;
		end else if (out_pop && !issue) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	logic                  d_valid;
	logic signed [Z_W-1:0] d_z;
	ctrl_t                 d_ctrl;

	aai_div #(.COORD_WIDTH(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (issue),
		.num       (b_num),
		.den       (b_den),
		.in_ctrl   (b_ctrl),
		.out_valid (d_valid),
		.z         (d_z),
		.out_ctrl  (d_ctrl)
	);

	logic               p_valid;
	logic [ANGLE_W-1:0] p_angle;

	aai_poly u_poly (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (d_valid),
		.z           (d_z),
		.in_ctrl     (d_ctrl),
		.out_valid   (p_valid),
		.angle_index (p_angle)
	);

	// Result queue: holds finished angles until the consumer pops them.
	logic                            outq_full;
	logic [$clog2(OUTQ_DEPTH+1)-1:0] outq_count;

	aai_fifo #(.WIDTH(ANGLE_W), .DEPTH(OUTQ_DEPTH)) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (p_valid),
		.wdata  (p_angle),
		.pop    (out_pop),
		.rdata  (angle_index),
		.empty  (empty),
		.full   (outq_full),
		.count  (outq_count)
	);

`include "atan2_angle_index_macros.svh"

	`AAI_NEVER(a_credit_bound, credit_q > CRED_W'(OUTQ_DEPTH), "credit count above queue depth")
	`AAI_NEVER(a_outq_within_credit, CRED_W'(outq_count) > credit_q, "result queue exceeds credits")
	`AAI_IMPLY(a_no_overflow, p_valid, !outq_full, "pipeline result dropped on full queue")
	`AAI_IMPLY(a_issue_nonempty, issue, mid_count != '0, "issue from an empty front queue")

endmodule

FILE: sv/aai_fifo.sv
module aai_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: sv/aai_front.sv
module aai_front #(
	parameter int COORD_WIDTH = 32
) (
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	output logic [COORD_WIDTH-1:0]        num,
	output logic [COORD_WIDTH-1:0]        den,
	output aai_pkg::ctrl_t                ctrl
);
	import aai_pkg::*;

	logic [COORD_WIDTH-1:0] ax, ay;
	logic                   x_neg, y_neg, x_zero, y_zero, x_major;

	always_comb begin
		x_neg   = x_coord[COORD_WIDTH-1];
		y_neg   = y_coord[COORD_WIDTH-1];
		x_zero  = (x_coord == '0);
		y_zero  = (y_coord == '0);
		ax      = x_neg ? (~x_coord + 1'b1) : x_coord;
		ay      = y_neg ? (~y_coord + 1'b1) : y_coord;
		x_major = (ax > ay);
		num     = x_major ? ay : ax;
		den     = x_major ? ax : ay;
	end

	always_comb begin
		ctrl.neg      = x_neg ^ y_neg;
		ctrl.axis_idx = ANGLE_ZERO;
		ctrl.oct      = OCT_AXIS;
		priority if (x_zero) begin
			ctrl.oct = OCT_AXIS;
			if (y_neg) begin
				ctrl.axis_idx = ANGLE_DOWN;
			end else if (!y_zero) begin
				ctrl.axis_idx = ANGLE_UP;
			end
		end else if (x_major) begin
			unique case ({x_neg, y_neg})
				2'b00: ctrl.oct = OCT_XPOS_YPOS;
				2'b01: ctrl.oct = OCT_XPOS_YNEG;
				2'b10: ctrl.oct = OCT_XNEG_YPOS;
				2'b11: ctrl.oct = OCT_XNEG_YNEG;
				default: ctrl.oct = OCT_AXIS;
			endcase
		end else begin
			ctrl.oct = y_neg ? OCT_YNEG : OCT_YPOS;
		end
	end

endmodule

FILE: sv/aai_div.sv
module aai_div #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [COORD_WIDTH-1:0]        num,
	input  logic [COORD_WIDTH-1:0]        den,
	input  aai_pkg::ctrl_t                in_ctrl,
	output logic                          out_valid,
	output logic signed [aai_pkg::Z_W-1:0] z,
	output aai_pkg::ctrl_t                out_ctrl
);
	import aai_pkg::*;

	localparam int W = COORD_WIDTH;

	logic [W-1:0]      rem_s  [Q_BITS];
	logic [W-1:0]      den_s  [Q_BITS];
	logic [Q_BITS-1:0] quo_s  [Q_BITS];
	ctrl_t             ctrl_s [Q_BITS];
	logic [Q_BITS-1:0] vld_s;

	logic [W:0]        cand   [Q_BITS];
	logic [W:0]        diff   [Q_BITS];
	logic [Q_BITS-1:0] ge;
	logic [Z_W-1:0]    zmag;

	// One quotient bit per stage, most significant first.
	always_comb begin
		cand[0] = {1'b0, num};
		diff[0] = cand[0] - {1'b0, den};
		ge[0]   = (cand[0] >= {1'b0, den});
		for (int k = 1; k < Q_BITS; k++) begin
			cand[k] = {rem_s[k-1], 1'b0};
			diff[k] = cand[k] - {1'b0, den_s[k-1]};
			ge[k]   = (cand[k] >= {1'b0, den_s[k-1]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[Q_BITS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= ge[0] ? diff[0][W-1:0] : cand[0][W-1:0];
		den_s[0]  <= den;
		quo_s[0]  <= {{(Q_BITS-1){1'b0}}, ge[0]};
		ctrl_s[0] <= in_ctrl;
		for (int k = 1; k < Q_BITS; k++) begin
			rem_s[k]  <= ge[k] ? diff[k][W-1:0] : cand[k][W-1:0];
			den_s[k]  <= den_s[k-1];
			quo_s[k]  <= {quo_s[k-1][Q_BITS-2:0], ge[k]};
			ctrl_s[k] <= ctrl_s[k-1];
		end
	end

	assign zmag      = {1'b0, quo_s[Q_BITS-1]};
	assign z         = ctrl_s[Q_BITS-1].neg ? $signed(-zmag) : $signed(zmag);
	assign out_valid = vld_s[Q_BITS-1];
	assign out_ctrl  = ctrl_s[Q_BITS-1];

endmodule

FILE: sv/aai_poly.sv
module aai_poly (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [aai_pkg::Z_W-1:0]    z,
	input  aai_pkg::ctrl_t                    in_ctrl,
	output logic                              out_valid,
	output logic [aai_pkg::ANGLE_W-1:0]       angle_index
);
	import aai_pkg::*;

	// s1: z squared
	logic signed [23:0]    zsq;
	logic [10:0]           zz_s1;
	logic signed [Z_W-1:0] z_s1;
	ctrl_t                 ctrl_s1;
	// s2: inner coefficient
	logic [18:0]           m2;
	logic signed [19:0]    nm2, nm2_sh;
	logic signed [11:0]    inner_c;
	logic signed [11:0]    inner_s2;
	logic signed [Z_W-1:0] z_s2;
	ctrl_t                 ctrl_s2;
	// s3: polynomial value
	logic signed [23:0]    tp;
	logic signed [13:0]    t_s3;
	ctrl_t                 ctrl_s3;
	// s4: octant operands
	logic signed [14:0]    tw, u_c;
	logic signed [18:0]    k_c;
	logic signed [21:0]    off_c;
	logic signed [14:0]    u_s4;
	logic signed [18:0]    k_s4;
	logic signed [21:0]    off_s4;
	ctrl_t                 ctrl_s4;
	// s5: scale, offset, integer part
	logic signed [33:0]    sp, sp_sh, r;
	logic [ANGLE_W-1:0]    angle_s5;
	logic [4:0]            vld_q;

	always_comb begin
		zsq     = z * z;
		m2      = K_N2_MAG * {8'd0, zz_s1};
		nm2     = -$signed({1'b0, m2});
		nm2_sh  = nm2 >>> 10;
		inner_c = $signed(nm2_sh[11:0]) + K_N1;
		tp      = inner_s2 * z_s2;
		tw      = {t_s3[13], t_s3};
	end

	always_comb begin
		k_c   = K_M1;
		u_c   = tw;
		off_c = '0;
		unique case (ctrl_s3.oct)
			OCT_XPOS_YPOS: begin
				k_c = K_M1; u_c = tw; off_c = '0;
			end
			OCT_XPOS_YNEG: begin
				k_c = K_M1; u_c = tw; off_c = K_FULL;
			end
			OCT_XNEG_YPOS: begin
				k_c = K_M1; u_c = tw + K_PI; off_c = K_B2;
			end
			OCT_XNEG_YNEG: begin
				k_c = K_M1; u_c = tw - K_PI; off_c = K_B3;
			end
			OCT_YPOS: begin
				k_c = K_M2; u_c = K_HALFPI - tw; off_c = -K_B4;
			end
			OCT_YNEG: begin
				k_c = -K_M2; u_c = K_HALFPI + tw; off_c = K_B5;
			end
			default: begin
				k_c = '0; u_c = '0; off_c = '0;
			end
		endcase
	end

	always_comb begin
		sp    = k_s4 * u_s4;
		sp_sh = sp >>> 10;
		r     = sp_sh + {{12{off_s4[21]}}, off_s4};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		zz_s1    <= zsq[20:10];
		z_s1     <= z;
		ctrl_s1  <= in_ctrl;
		inner_s2 <= inner_c;
		z_s2     <= z_s1;
		ctrl_s2  <= ctrl_s1;
		t_s3     <= tp[23:10];
		ctrl_s3  <= ctrl_s2;
		k_s4     <= k_c;
		u_s4     <= u_c;
		off_s4   <= off_c;
		ctrl_s4  <= ctrl_s3;
		angle_s5 <= (ctrl_s4.oct == OCT_AXIS) ? ctrl_s4.axis_idx : r[19:10];
	end

	assign out_valid   = vld_q[4];
	assign angle_index = angle_s5;

endmodule
